/* hw/rtl/sli_pkg.sv */
// Shared types and codes for the sorted insertion list.
// Used by the channel interfaces, the list cell and the top level.
package sli_pkg;

	typedef logic signed [31:0] value_t;

	// Request kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_INSERTED  = 2'd0,
		STATUS_REMOVED   = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

	// Broadcast shift control from the top level to every cell.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} cell_ctrl_t;

endpackage

/* hw/rtl/sli_req_if.sv */
// Request channel of the sorted insertion list: valid, ready and payload.
// Depends on sli_pkg for the value type.
interface sli_req_if;
	logic            valid;
	logic            ready;
	logic            kind;
	sli_pkg::value_t value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

/* hw/rtl/sli_rsp_if.sv */
// Result channel of the sorted insertion list: valid, ready and payload.
// Depends on sli_pkg for the value and status types.
interface sli_rsp_if;
	logic             valid;
	logic             ready;
	sli_pkg::status_t status;
	logic [4:0]       entry_count;
	sli_pkg::value_t  smallest;

	modport source (output valid, output status, output entry_count, output smallest,
		input ready);
	modport sink   (input valid, input status, input entry_count, input smallest,
		output ready);
endinterface

/* hw/rtl/sli_cell.sv */
// One entry of the sorted insertion list with its compare and shift logic.
// Depends on sli_pkg for the value type and the broadcast control struct.
module sli_cell (
	input  logic                clk,
	input  sli_pkg::value_t     value,
	input  sli_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                left_before,
	input  sli_pkg::value_t     left_entry,
	input  sli_pkg::value_t     right_entry,
	output logic                lt,
	output logic                hit,
	output sli_pkg::value_t     entry,
	output sli_pkg::value_t     entry_nxt
);

	sli_pkg::value_t entry_q;

	// The stored entry is handed to both neighbors.
	assign entry = entry_q;

	// This cell lies before the request's sorted place.
	assign lt  = occ && (entry_q < value);
	// This cell is the first one at or past the place and holds the value.
	assign hit = left_before && !lt && occ && (entry_q == value);

	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.ins_en && !lt) begin
			entry_nxt = left_before ? value : left_entry;
		end else if (ctrl.rem_en && !lt) begin
			entry_nxt = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

/* hw/rtl/sorted_list_insert_remove_top.sv */
// Top level of the sorted insertion list: a row of compare-and-shift cells.
// Depends on sli_pkg, sli_req_if, sli_rsp_if and sli_cell.
//
//  Channel | Dir | Fields                             | Meaning
//  --------+-----+------------------------------------+---------------------------------
//  req     | in  | kind, value                        | insert value or remove one copy
//  rsp     | out | status, entry_count, smallest      | outcome, new count, head value
//
// Every request is finished on the edge it is accepted: all cells compare the
// broadcast value at once and shift one place left or right on that edge, and
// the result is presented from the next cycle on.
// One request per cycle is sustained while each result is taken as it is presented;
// the rate is set by the compare, the found reduction over the row and the shift multiplexer in each cell.
// Reset clears the entry count and the result valid flag; cell contents are
// left as they are, since only cells below the count are ever looked at.
// The result register frees the request side: a new request is taken while
// the last result is being taken, and the block stalls only if it is not.
module sorted_list_insert_remove_top #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	sli_req_if.sink   req,
	sli_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic                out_valid_q;
	sli_pkg::status_t    status_q;
	logic [4:0]          entry_count_q;
	sli_pkg::value_t     smallest_q;

	logic                accept;
	logic                full;
	logic                found;
	sli_pkg::status_t    status_nxt;
	sli_pkg::cell_ctrl_t ctrl;

	logic            cell_lt    [CAPACITY];
	logic            cell_hit   [CAPACITY];
	sli_pkg::value_t cell_entry [CAPACITY];
	sli_pkg::value_t cell_nxt   [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	// A request is taken whenever the result register is free or draining.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));

	// Only one cell can sit at the boundary, so an OR over the row tells
	// whether the value to remove is present.
	assign found = |hit_vec;

	assign ctrl.ins_en = accept && (req.kind == sli_pkg::KIND_INSERT) && !full;
	assign ctrl.rem_en = accept && (req.kind == sli_pkg::KIND_REMOVE) && found;

	// The row of cells. The first cell always counts as past its left
	// neighbor, and the ends are fed with the request value as filler.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic            left_before;
		sli_pkg::value_t left_entry;
		sli_pkg::value_t right_entry;

		if (i == 0) begin : g_first
			assign left_before = 1'b1;
			assign left_entry  = req.value;
		end else begin : g_mid
			assign left_before = cell_lt[i-1];
			assign left_entry  = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = req.value;
		end else begin : g_next
			assign right_entry = cell_entry[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.value       (req.value),
			.ctrl        (ctrl),
			.occ         (CW'(i) < count_q),
			.left_before (left_before),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.lt          (cell_lt[i]),
			.hit         (cell_hit[i]),
			.entry       (cell_entry[i]),
			.entry_nxt   (cell_nxt[i])
		);

		assign hit_vec[i] = cell_hit[i];
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins_en) begin
			count_nxt = count_q + CW'(1);
		end else if (ctrl.rem_en) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_comb begin
		if (req.kind == sli_pkg::KIND_INSERT) begin
			status_nxt = full ? sli_pkg::STATUS_FULL : sli_pkg::STATUS_INSERTED;
		end else begin
			status_nxt = found ? sli_pkg::STATUS_REMOVED : sli_pkg::STATUS_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the head cell's next value is the new smallest entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nxt;
			entry_count_q <= 5'(count_nxt);
			smallest_q    <= (count_nxt != '0) ? cell_nxt[0] : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.smallest    = smallest_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |=> (count_q == $past(count_q) + CW'(1))
			&& (status_q == sli_pkg::STATUS_INSERTED))
		else $error("insert did not grow the list by one");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.kind == sli_pkg::KIND_INSERT) && full)
			|=> $stable(count_q) && (status_q == sli_pkg::STATUS_FULL))
		else $error("insert into a full list changed the count");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell claims the removal");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (entry_count_q == 5'd0) && (CAPACITY < 32)) |-> (smallest_q == '0))
		else $error("empty list reports a nonzero smallest value");

endmodule
